// ----- rtl/ftsc_pkg.sv -----
package ftsc_pkg;

    // slot numbers travel at the widest the table can be (up to 256 slots)
    localparam int SLOT_MAX_W = 8;
    localparam int CODE_W     = 6;
    localparam int LOC_W      = 2;
    localparam int TIME_W     = 32;
    localparam int IDX_W      = 4;

    typedef logic [SLOT_MAX_W-1:0] slot_t;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_FULL       = 3'd2,
        ST_REMOVED    = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_READ_VALID = 3'd5,
        ST_READ_EMPTY = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_HOLD
    } fsm_t;

    // query beat walking down the slot chain, picking up results as it goes
    typedef struct packed {
        logic              live;
        op_t               op;
        logic              key_ok;
        logic [CODE_W-1:0] code;
        logic [LOC_W-1:0]  loc;
        logic [IDX_W-1:0]  idx;
        logic              hit;
        slot_t             hit_slot;
        logic              free_found;
        slot_t             free_slot;
        logic              rd_valid;
        logic [CODE_W-1:0] rd_code;
        logic [LOC_W-1:0]  rd_loc;
        logic [TIME_W-1:0] rd_time;
    } beat_t;

    // update broadcast to all slot cells at the end of a scan
    typedef struct packed {
        logic              set;
        logic              clr;
        slot_t             slot;
        logic [CODE_W-1:0] code;
        logic [LOC_W-1:0]  loc;
        logic [TIME_W-1:0] time_val;
    } wr_t;

endpackage

// ----- rtl/fault_table_set_clear_top.sv -----
// fault table: one operation at a time; the next input beat is taken only once the
// result of the last one has moved into the output register
// the query walks through the TABLE_SLOTS - 1 slot cell registers in turn, then a commit
// step updates the table and loads the result register, then the output register loads
// a result may wait on m_tready while the next operation runs
// aresetn (sync, active low) empties every slot and zeroes the active count
module fault_table_set_clear_top #(
    parameter int TABLE_SLOTS   = 16,
    parameter int NUM_CODES     = 64,
    parameter int NUM_LOCATIONS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [7:2] fault_id, [9:8] location,
    // [41:10] timestamp, [45:42] slot_index, [47:46] zero
    input  logic [47:0] s_tdata,
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [6:3] slot, [12:7] entry_code, [14:13] entry_location,
    // [46:15] entry_time, [50:47] active_count, [55:51] zero
    output logic [55:0] m_tdata
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    // chain[0] is the injected query, chain[TABLE_SLOTS-1] leaves the last cell
    ftsc_pkg::beat_t chain [TABLE_SLOTS];
    ftsc_pkg::beat_t head;
    ftsc_pkg::beat_t tail;
    ftsc_pkg::wr_t   wr;

    ftsc_pkg::fsm_t  state_reg, state_next;

    logic [SLOT_W-1:0]             count_reg, count_next;
    logic [ftsc_pkg::TIME_W-1:0]   time_reg;       // timestamp of the running set
    logic [55:0]                   res_reg, res_next;
    logic                          res_load;
    logic                          out_load;
    logic                          m_valid_reg;
    logic [55:0]                   m_data_reg;
    logic                          s_accept;

    // result fields built at the end of a scan
    ftsc_pkg::status_t             r_status;
    ftsc_pkg::slot_t               r_slot;
    ftsc_pkg::slot_t               cnt_ext;
    logic                          idx_in_range;

    assign s_accept = s_tvalid && s_tready;

    // query enters the first slot cell on the accept edge
    always_comb begin
        head            = '0;
        head.live       = s_accept;
        head.op         = ftsc_pkg::op_t'(s_tdata[1:0]);
        head.code       = s_tdata[7:2];
        head.loc        = s_tdata[9:8];
        head.idx        = s_tdata[45:42];
        // codes or locations beyond the table's range never match anything
        head.key_ok     = (32'(s_tdata[7:2]) < NUM_CODES) &&
                          (32'(s_tdata[9:8]) < NUM_LOCATIONS);
    end

    assign chain[0] = head;

    // slot 0 is never used, cells hold slots 1 .. TABLE_SLOTS-1
    for (genvar i = 1; i < TABLE_SLOTS; i++) begin : g_cell
        ftsc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .slot_id  (ftsc_pkg::slot_t'(i)),
            .beat_in  (chain[i-1]),
            .wr       (wr),
            .beat_out (chain[i])
        );
    end

    assign tail = chain[TABLE_SLOTS-1];

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            time_reg <= s_tdata[41:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ftsc_pkg::FSM_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        s_tready     = 1'b0;
        res_load     = 1'b0;
        out_load     = 1'b0;
        wr           = '0;
        r_status     = ftsc_pkg::ST_READ_EMPTY;
        r_slot       = '0;
        idx_in_range = 32'(tail.idx) < TABLE_SLOTS;

        // decision on what the scan collected
        case (tail.op)
            ftsc_pkg::OP_SET: begin
                if (tail.hit) begin
                    r_status = ftsc_pkg::ST_DUPLICATE;
                    r_slot   = tail.hit_slot;
                end else if (tail.key_ok && tail.free_found) begin
                    r_status     = ftsc_pkg::ST_ADDED;
                    r_slot       = tail.free_slot;
                    wr.set       = tail.live;
                    wr.slot      = tail.free_slot;
                    wr.code      = tail.code;
                    wr.loc       = tail.loc;
                    wr.time_val  = time_reg;
                end else begin
                    r_status = ftsc_pkg::ST_FULL;
                end
            end
            ftsc_pkg::OP_CLEAR: begin
                if (tail.hit) begin
                    r_status = ftsc_pkg::ST_REMOVED;
                    r_slot   = tail.hit_slot;
                    wr.clr   = tail.live;
                    wr.slot  = tail.hit_slot;
                end else begin
                    r_status = ftsc_pkg::ST_NOT_FOUND;
                end
            end
            ftsc_pkg::OP_READ: begin
                if (idx_in_range) begin
                    r_slot = ftsc_pkg::slot_t'(tail.idx);
                end
                // slot 0 has no cell, so it always reads empty
                if (tail.rd_valid) begin
                    r_status = ftsc_pkg::ST_READ_VALID;
                end
            end
            default: begin
                r_status = ftsc_pkg::ST_READ_EMPTY;
            end
        endcase

        // only commit the update while the scan really ends
        if (state_reg != ftsc_pkg::FSM_SCAN) begin
            wr = '0;
        end

        case (state_reg)
            ftsc_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ftsc_pkg::FSM_SCAN;
                end
            end
            ftsc_pkg::FSM_SCAN: begin
                if (tail.live) begin
                    res_load   = 1'b1;
                    state_next = ftsc_pkg::FSM_HOLD;
                    if (wr.set) begin
                        count_next = count_reg + SLOT_W'(1);
                    end else if (wr.clr && count_reg != '0) begin
                        count_next = count_reg - SLOT_W'(1);
                    end
                end
            end
            ftsc_pkg::FSM_HOLD: begin
                // move the result into the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ftsc_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = ftsc_pkg::FSM_IDLE;
            end
        endcase

        cnt_ext  = ftsc_pkg::slot_t'(count_next);
        res_next = {5'd0,
                    cnt_ext[3:0],
                    tail.rd_valid ? tail.rd_time : 32'd0,
                    tail.rd_valid ? tail.rd_loc : 2'd0,
                    tail.rd_valid ? tail.rd_code : 6'd0,
                    r_slot[3:0],
                    r_status};
        // reads only carry entry contents, everything else answers zeros
        if (tail.op != ftsc_pkg::OP_READ) begin
            res_next[46:7] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    // output register parts the result side from the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/ftsc_cell.sv -----
module ftsc_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  ftsc_pkg::slot_t slot_id,
    input  ftsc_pkg::beat_t beat_in,
    input  ftsc_pkg::wr_t   wr,
    output ftsc_pkg::beat_t beat_out
);

    logic                          valid_reg;
    logic [ftsc_pkg::CODE_W-1:0]   code_reg;
    logic [ftsc_pkg::LOC_W-1:0]    loc_reg;
    logic [ftsc_pkg::TIME_W-1:0]   time_reg;
    ftsc_pkg::beat_t               beat_reg;
    ftsc_pkg::beat_t               beat_next;

    always_comb begin
        beat_next = beat_in;
        // lowest matching slot wins, the beat visits slots in rising order
        if (beat_in.key_ok && !beat_in.hit && valid_reg &&
            code_reg == beat_in.code && loc_reg == beat_in.loc) begin
            beat_next.hit      = 1'b1;
            beat_next.hit_slot = slot_id;
        end
        if (!beat_in.free_found && !valid_reg) begin
            beat_next.free_found = 1'b1;
            beat_next.free_slot  = slot_id;
        end
        if (valid_reg && ftsc_pkg::slot_t'(beat_in.idx) == slot_id) begin
            beat_next.rd_valid = 1'b1;
            beat_next.rd_code  = code_reg;
            beat_next.rd_loc   = loc_reg;
            beat_next.rd_time  = time_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= '0;
        end else begin
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr.slot == slot_id) begin
            if (wr.set) begin
                valid_reg <= 1'b1;
            end else if (wr.clr) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.slot == slot_id) begin
            if (wr.set) begin
                code_reg <= wr.code;
                loc_reg  <= wr.loc;
                time_reg <= wr.time_val;
            end else if (wr.clr) begin
                code_reg <= '0;
            end
        end
    end

    assign beat_out = beat_reg;

endmodule
